/* rtl/core/bld_pkg.sv */
// Shared constants, codes and control types of the blinking LED shift driver.
package bld_pkg;

  localparam int MAX_LEDS   = 64;
  localparam int POS_W      = $clog2(MAX_LEDS);
  localparam int CNT_W      = 7;
  localparam int PERIOD_W   = 16;
  localparam int PHASE_W    = 3;
  localparam int MODE_W     = 4;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Operation codes of the input channel
  localparam logic [OP_W-1:0] OP_SET_ONE = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_ALL = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 2'd1;

  localparam logic [CNT_W-1:0]    RESET_COUNT  = 7'd64;
  localparam logic [PERIOD_W-1:0] RESET_PERIOD = 16'd150;
  localparam logic [CNT_W-1:0]    MAX_COUNT    = 7'(MAX_LEDS);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             tick;
    logic             set_all;
    logic             mode_ld;
    logic             rd_rmw;
    logic             rmw_chk;
    logic             sweep_wr;
    logic             rd_frame;
    logic             rd_last;
    logic [POS_W-1:0] addr;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic             emit;
    logic             can_issue;
    logic             rd_pend;
  } sts_t;

endpackage

/* rtl/core/bld_in_if.sv */
// Input channel: operation, LED index and mode.
interface bld_in_if;
  logic                         valid;
  logic                         ready;
  logic [bld_pkg::OP_W-1:0]     operation;
  logic [bld_pkg::POS_W-1:0]    led_index;
  logic [bld_pkg::MODE_W-1:0]   led_mode;

  modport source (output valid, output operation, output led_index, output led_mode,
                  input ready);
  modport sink   (input valid, input operation, input led_index, input led_mode,
                  output ready);
endinterface

/* rtl/core/bld_out_if.sv */
// Output channel: one serial bit of a frame per beat.
interface bld_out_if;
  logic                      valid;
  logic                      ready;
  logic                      serial_bit;
  logic [bld_pkg::POS_W-1:0] led_position;
  logic                      frame_last;

  modport source (output valid, output serial_bit, output led_position, output frame_last,
                  input ready);
  modport sink   (input valid, input serial_bit, input led_position, input frame_last,
                  output ready);
endinterface

/* rtl/core/bld_cfg_if.sv */
// Configuration write channel: register index and write data.
interface bld_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bld_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [bld_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

/* rtl/core/bld_ram.sv */
// Generic single-port-address RAM with registered read.
module bld_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/core/bld_dpath.sv */
// Datapath: mode store, blink timing, configuration and output register.
module bld_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  bld_pkg::cmd_t                cmd,
  output bld_pkg::sts_t                sts,
  input  logic [bld_pkg::MODE_W-1:0]   led_mode,
  bld_cfg_if.sink                      cfg_ch,
  bld_out_if.source                    out_ch
);

  logic [bld_pkg::CNT_W-1:0]    led_count;
  logic [bld_pkg::PERIOD_W-1:0] blink_period;
  logic [bld_pkg::PERIOD_W-1:0] ms_counter;
  logic [bld_pkg::PHASE_W-1:0]  blink_phase;
  logic                         update_pending;
  logic [bld_pkg::MODE_W-1:0]   mode_reg;
  logic [bld_pkg::MAX_LEDS-1:0] vld;
  logic                         vq;
  logic                         rd_pend;
  logic [bld_pkg::POS_W-1:0]    rd_pos;
  logic                         rd_last;
  logic [bld_pkg::MODE_W-1:0]   rdata;
  logic [bld_pkg::MODE_W-1:0]   rmode;
  logic [bld_pkg::PERIOD_W:0]   cnt_inc;
  logic                         wrap;
  logic                         ram_we;
  logic                         ram_re;
  logic                         load;
  logic                         out_valid;
  logic                         out_bit;
  logic [bld_pkg::POS_W-1:0]    out_pos;
  logic                         out_last;

  // Count saturated to the chain limit
  assign sts.n = (led_count > bld_pkg::MAX_COUNT) ? bld_pkg::MAX_COUNT : led_count;

  // Blink counter step
  assign cnt_inc  = {1'b0, ms_counter} + 17'd1;
  assign wrap     = cnt_inc >= {1'b0, blink_period};
  assign sts.emit = update_pending | wrap;

  // Mode read back; never-written entries read as off
  assign rmode  = vq ? rdata : '0;
  assign ram_we = cmd.sweep_wr | (cmd.rmw_chk & (rmode != mode_reg));
  assign ram_re = cmd.rd_rmw | cmd.rd_frame;

  bld_ram #(
    .WIDTH (bld_pkg::MODE_W),
    .DEPTH (bld_pkg::MAX_LEDS)
  ) u_mode_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (cmd.addr),
    .wdata (mode_reg),
    .rdata (rdata)
  );

  // Frame read data moves into the output register when it is free
  assign load          = rd_pend & (~out_valid | out_ch.ready);
  assign sts.can_issue = ~rd_pend | load;
  assign sts.rd_pend   = rd_pend;

  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid;
  assign out_ch.serial_bit   = out_bit;
  assign out_ch.led_position = out_pos;
  assign out_ch.frame_last   = out_last;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count      <= bld_pkg::RESET_COUNT;
      blink_period   <= bld_pkg::RESET_PERIOD;
      ms_counter     <= '0;
      blink_phase    <= '0;
      update_pending <= 1'b1;
      vld            <= '0;
      rd_pend        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.reg_index)
          bld_pkg::CFG_LED_COUNT:    led_count    <= cfg_ch.wdata[bld_pkg::CNT_W-1:0];
          bld_pkg::CFG_BLINK_PERIOD: blink_period <= cfg_ch.wdata;
          default: ;
        endcase
      end
      if (cmd.tick) begin
        ms_counter     <= wrap ? '0 : cnt_inc[bld_pkg::PERIOD_W-1:0];
        blink_phase    <= blink_phase + bld_pkg::PHASE_W'(wrap);
        update_pending <= 1'b0;
      end else if (cmd.set_all || ram_we) begin
        update_pending <= 1'b1;
      end
      if (ram_we) begin
        vld[cmd.addr] <= 1'b1;
      end
      if (cmd.rd_frame) begin
        rd_pend <= 1'b1;
      end else if (load) begin
        rd_pend <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.mode_ld) begin
      mode_reg <= led_mode;
    end
    if (ram_re) begin
      vq <= vld[cmd.addr];
    end
    if (cmd.rd_frame) begin
      rd_pos  <= cmd.addr;
      rd_last <= cmd.rd_last;
    end
    if (load) begin
      out_bit  <= |(rmode & {1'b1, blink_phase});
      out_pos  <= rd_pos;
      out_last <= rd_last;
    end
  end

endmodule

/* rtl/core/bld_ctrl.sv */
// Controller: accepts items and sequences store updates and frame reads.
module bld_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bld_pkg::OP_W-1:0]   operation,
  input  logic [bld_pkg::POS_W-1:0]  led_index,
  output bld_pkg::cmd_t              cmd,
  input  bld_pkg::sts_t              sts
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RMW   = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_FRAME = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  logic [2:0]                state;
  logic [2:0]                state_next;
  logic [bld_pkg::POS_W-1:0] pos;
  logic [bld_pkg::POS_W-1:0] pos_next;
  logic [bld_pkg::CNT_W-1:0] nm1;

  assign nm1 = sts.n - 7'd1;

  // Next state and commands
  always_comb begin
    state_next = state;
    pos_next   = pos;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.addr   = pos;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.addr = led_index;
        if (in_valid) begin
          unique case (operation)
            bld_pkg::OP_SET_ONE: begin
              if ({1'b0, led_index} < sts.n) begin
                cmd.rd_rmw  = 1'b1;
                cmd.mode_ld = 1'b1;
                pos_next    = led_index;
                state_next  = ST_RMW;
              end
            end
            bld_pkg::OP_SET_ALL: begin
              cmd.mode_ld = 1'b1;
              cmd.set_all = 1'b1;
              if (sts.n != '0) begin
                pos_next   = '0;
                state_next = ST_SWEEP;
              end
            end
            bld_pkg::OP_TICK: begin
              cmd.tick = 1'b1;
              if (sts.emit && sts.n != '0) begin
                pos_next   = nm1[bld_pkg::POS_W-1:0];
                state_next = ST_FRAME;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RMW: begin
        cmd.rmw_chk = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if ({1'b0, pos} == nm1) begin
          state_next = ST_IDLE;
        end else begin
          pos_next = pos + 6'd1;
        end
      end
      ST_FRAME: begin
        if (sts.can_issue) begin
          cmd.rd_frame = 1'b1;
          cmd.rd_last  = (pos == '0);
          if (pos == '0) begin
            state_next = ST_DRAIN;
          end else begin
            pos_next = pos - 6'd1;
          end
        end
      end
      ST_DRAIN: begin
        if (!sts.rd_pend) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
    end
  end

endmodule

/* rtl/core/blinking_led_shift_driver_top.sv */
// Top level of the blinking LED shift driver.
//
//  channel  | dir | beat payload                           | accepted when
//  ---------+-----+----------------------------------------+-----------------
//  in_ch    | in  | operation, led_index, led_mode         | valid & ready
//  out_ch   | out | serial_bit, led_position, frame_last   | valid & ready
//  cfg_ch   | in  | reg_index, wdata                       | valid & ready
//
// Set one LED reads the old mode, then writes the new one if it changed.
// Set all writes every LED up to the count, one store write per cycle.
// A tick that sends a frame reads one bit per cycle while the output does not stall,
// through the single mode RAM port.
// Reset is synchronous; all modes read as off through per-LED valid bits and
// the first frame is pending. Configuration is always ready.
module blinking_led_shift_driver_top (
  input  logic      clk,
  input  logic      rst,
  bld_in_if.sink    in_ch,
  bld_out_if.source out_ch,
  bld_cfg_if.sink   cfg_ch
);

  bld_pkg::cmd_t cmd;
  bld_pkg::sts_t sts;

  bld_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .operation (in_ch.operation),
    .led_index (in_ch.led_index),
    .cmd       (cmd),
    .sts       (sts)
  );

  bld_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .led_mode (in_ch.led_mode),
    .cfg_ch   (cfg_ch),
    .out_ch   (out_ch)
  );

  // Input is taken only with no frame read outstanding
  a_idle_no_read: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !sts.rd_pend)
    else $error("input ready while a frame read is outstanding");

  // Frame reads are issued only when the read slot is free
  a_issue_free: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_frame |-> sts.can_issue)
    else $error("frame read issued over a pending read");

  // Store writes and frame reads never share a cycle
  a_no_wr_rd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.sweep_wr && cmd.rd_frame))
    else $error("store write and frame read in the same cycle");

endmodule
